// ===== hw/rtl/gbn_pkg.sv =====
// Shared types and constants for the Go-Back-N sender window core.
// No dependencies; every other file in hw/rtl imports this package.
package gbn_pkg;

  // Field widths fixed by the channel and register definitions
  localparam int ACTION_W   = 2;
  localparam int PKT_W      = 16;
  localparam int WIN_W      = 6;
  localparam int TOT_W      = 16;
  localparam int TMO_W      = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Action codes carried on the input channel
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ACK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PACKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd2;

  // Register reset values
  localparam logic [WIN_W-1:0] WINDOW_RST  = 6'd4;
  localparam logic [TOT_W-1:0] TOTAL_RST   = 16'd0;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd100;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic tick;
    logic ack_fin;
    logic ack_slide;
    logic resend_init;
    logic fill_emit;
    logic resend_emit;
    logic fin_emit;
  } gbn_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic total_zero;
    logic tick_elig;
    logic timed_out;
    logic ack_fin;
    logic ack_slide;
    logic fill_more;
    logic fill_last;
    logic resend_last;
    logic out_free;
  } gbn_sts_t;

endpackage

// ===== hw/rtl/gbn_in_if.sv =====
// Input channel interface: valid/ready handshake with action and ack number.
// Depends on gbn_pkg for field widths.
interface gbn_in_if import gbn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PKT_W-1:0]    ack_number;

  modport source (output valid, output action, output ack_number, input ready);
  modport sink   (input valid, input action, input ack_number, output ready);
endinterface

// ===== hw/rtl/gbn_out_if.sv =====
// Result channel interface: valid/ready handshake with one send command.
// Depends on gbn_pkg for field widths.
interface gbn_out_if import gbn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PKT_W-1:0] packet_number;
  logic             is_resend;
  logic             finished;
  logic             last_of_run;

  modport source (output valid, output packet_number, output is_resend,
                  output finished, output last_of_run, input ready);
  modport sink   (input valid, input packet_number, input is_resend,
                  input finished, input last_of_run, output ready);
endinterface

// ===== hw/rtl/go_back_n_sender_window_core.sv =====
// Top level of the Go-Back-N sender window core: controller plus datapath.
// Depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_ctrl and gbn_datapath.
//
//  Channel   Direction  Handshake         Payload
//  in_ch     sink       valid / ready     action, ack_number
//  out_ch    source     valid / ready     packet_number, is_resend, finished, last_of_run
//  cfg_*     sink       cfg_we only       cfg_index, cfg_data
//
// An item is taken while the sequencer is idle; a start or ack then produces its
// results one per cycle (up to MAX_WINDOW), a tick first compares the base packet's
// age in S_TICK_CMP and, if it has timed out, resends one packet per cycle. The pace is
// set by the single result register and the one write port of the send-time memory.
// rst_n is synchronous; the send-time memory is not cleared and is used only for packets
// in flight. A stalled out_ch holds the sequencer; in_ch is not ready meanwhile.
module go_back_n_sender_window_core import gbn_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gbn_in_if.sink                in_ch,
  gbn_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  // Sequence each transaction
  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold window state and drive results
  gbn_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_ack_number     (in_ch.ack_number),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_packet_number (out_ch.packet_number),
    .out_is_resend     (out_ch.is_resend),
    .out_finished      (out_ch.finished),
    .out_last_of_run   (out_ch.last_of_run)
  );

endmodule

// ===== hw/rtl/gbn_datapath.sv =====
// Datapath: configuration registers, window pointers, tick counter, send-time
// memory and the result register. Depends on gbn_pkg; driven by gbn_ctrl.
module gbn_datapath import gbn_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PKT_W-1:0]      in_ack_number,
  input  gbn_cmd_t              cmd,
  output gbn_sts_t              sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PKT_W-1:0]      out_packet_number,
  output logic                  out_is_resend,
  output logic                  out_finished,
  output logic                  out_last_of_run
);

  // Compare width covers both packet ports and the sequence space plus a carry
  localparam int CW    = ((SEQ_BITS > PKT_W) ? SEQ_BITS : PKT_W) + 1;
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH = 1 << IDX_W;

  logic [WIN_W-1:0]    win_r;
  logic [TOT_W-1:0]    total_r;
  logic [TMO_W-1:0]    tmo_r;
  logic [SEQ_BITS-1:0] base_r;
  logic [SEQ_BITS-1:0] next_r;
  logic [SEQ_BITS-1:0] cur_r;
  logic [TIME_W-1:0]   time_r;
  logic                active_r;
  logic                done_r;
  logic [TIME_W-1:0]   send_mem [DEPTH];
  logic [TIME_W-1:0]   rd_data_r;
  logic                out_valid_r;
  logic [PKT_W-1:0]    out_pkt_r;
  logic                out_resend_r;
  logic                out_fin_r;
  logic                out_last_r;

  logic [CW-1:0]     win_cw;
  logic [CW-1:0]     eff_win;
  logic [CW-1:0]     seq_mask_cw;
  logic [CW-1:0]     total_cw;
  logic [CW-1:0]     eff_total;
  logic [CW-1:0]     base_cw;
  logic [CW-1:0]     next_cw;
  logic [CW-1:0]     cur_cw;
  logic [CW-1:0]     ack_cw;
  logic [CW-1:0]     limit;
  logic [CW-1:0]     next_inc;
  logic [CW-1:0]     cur_inc;
  logic [CW-1:0]     ack_inc;
  logic [TIME_W-1:0] age;
  logic              running;
  logic              ack_ok;
  logic              ack_last;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= WINDOW_RST;
      total_r <= TOTAL_RST;
      tmo_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_PACKETS: win_r   <= cfg_data[WIN_W-1:0];
        CFG_TOTAL_PACKETS:  total_r <= cfg_data[TOT_W-1:0];
        CFG_TIMEOUT_TICKS:  tmo_r   <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window and total, then derive window limits
  always_comb begin
    win_cw      = CW'(win_r);
    eff_win     = (win_r == '0) ? CW'(1) :
                  ((win_cw > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : win_cw);
    seq_mask_cw = CW'({SEQ_BITS{1'b1}});
    total_cw    = CW'(total_r);
    eff_total   = (total_cw > seq_mask_cw) ? seq_mask_cw : total_cw;
    base_cw     = CW'(base_r);
    next_cw     = CW'(next_r);
    cur_cw      = CW'(cur_r);
    ack_cw      = CW'(in_ack_number);
    limit       = base_cw + eff_win;
    next_inc    = next_cw + CW'(1);
    cur_inc     = cur_cw + CW'(1);
    ack_inc     = ack_cw + CW'(1);
    age         = time_r - rd_data_r;
    running     = active_r && !done_r;
    ack_ok      = running && (ack_cw < next_cw);
    ack_last    = (ack_inc == eff_total);
  end

  // Report status to the controller
  always_comb begin
    sts.total_zero  = (eff_total == '0);
    sts.tick_elig   = running && (base_r < next_r);
    sts.timed_out   = (age > TIME_W'(tmo_r));
    sts.ack_fin     = ack_ok && ack_last;
    sts.ack_slide   = ack_ok && !ack_last && (ack_cw >= base_cw);
    sts.fill_more   = (next_cw < limit) && (next_cw < eff_total);
    sts.fill_last   = (next_inc >= limit) || (next_inc >= eff_total);
    sts.resend_last = (cur_inc == next_cw);
    sts.out_free    = !out_valid_r || out_ready;
  end

  // Update window pointers, time and transfer flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      next_r   <= '0;
      cur_r    <= '0;
      time_r   <= '0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        base_r   <= '0;
        next_r   <= '0;
        done_r   <= sts.total_zero;
        active_r <= !sts.total_zero;
      end
      if (cmd.tick) begin
        time_r <= time_r + TIME_W'(1);
      end
      if (cmd.ack_fin) begin
        done_r   <= 1'b1;
        active_r <= 1'b0;
        base_r   <= next_r;
      end
      if (cmd.ack_slide) begin
        base_r <= SEQ_BITS'(ack_inc);
      end
      if (cmd.fill_emit) begin
        next_r <= SEQ_BITS'(next_inc);
      end
      if (cmd.resend_init) begin
        cur_r <= base_r;
      end
      if (cmd.resend_emit) begin
        cur_r <= SEQ_BITS'(cur_inc);
      end
    end
  end

  // Record send times; fetch the base packet's send time on a tick
  always_ff @(posedge clk) begin
    if (cmd.fill_emit) begin
      send_mem[next_r[IDX_W-1:0]] <= time_r;
    end else if (cmd.resend_emit) begin
      send_mem[cur_r[IDX_W-1:0]] <= time_r;
    end
    if (cmd.tick) begin
      rd_data_r <= send_mem[base_r[IDX_W-1:0]];
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fill_emit || cmd.resend_emit || cmd.fin_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (cmd.fill_emit) begin
      out_pkt_r    <= PKT_W'(next_r);
      out_resend_r <= 1'b0;
      out_fin_r    <= 1'b0;
      out_last_r   <= sts.fill_last;
    end else if (cmd.resend_emit) begin
      out_pkt_r    <= PKT_W'(cur_r);
      out_resend_r <= 1'b1;
      out_fin_r    <= 1'b0;
      out_last_r   <= sts.resend_last;
    end else if (cmd.fin_emit) begin
      out_pkt_r    <= '0;
      out_resend_r <= 1'b0;
      out_fin_r    <= 1'b1;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_number = out_pkt_r;
  assign out_is_resend     = out_resend_r;
  assign out_finished      = out_fin_r;
  assign out_last_of_run   = out_last_r;

  // A finished transfer is never also running
  a_done_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && active_r))
    else $error("transfer both done and active");

  // The window base never passes the next packet to send
  a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= next_r)
    else $error("window base beyond next packet");

  // Each new send advances the next packet number by one
  a_fill_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_emit |=> (next_r == SEQ_BITS'($past(next_r) + SEQ_BITS'(1))))
    else $error("next packet number did not advance on send");

endmodule

// ===== hw/rtl/gbn_ctrl.sv =====
// Controller: decodes accepted items and sequences send, resend and finish
// results one per cycle when out_free. Depends on gbn_pkg; drives gbn_datapath.
module gbn_ctrl import gbn_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [ACTION_W-1:0] in_action,
  output logic                in_ready,
  input  gbn_sts_t            sts,
  output gbn_cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_CMP,
    S_FILL,
    S_RESEND,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Decode the state into datapath commands and the next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_TICK: begin
              cmd.tick  = 1'b1;
              state_nxt = sts.tick_elig ? S_TICK_CMP : S_IDLE;
            end
            ACT_START: begin
              cmd.start = 1'b1;
              state_nxt = sts.total_zero ? S_FIN : S_FILL;
            end
            ACT_ACK: begin
              if (sts.ack_fin) begin
                cmd.ack_fin = 1'b1;
                state_nxt   = S_FIN;
              end else if (sts.ack_slide) begin
                cmd.ack_slide = 1'b1;
                state_nxt     = S_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK_CMP: begin
        if (sts.timed_out) begin
          cmd.resend_init = 1'b1;
          state_nxt       = S_RESEND;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (!sts.fill_more) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.fill_emit = 1'b1;
          if (sts.fill_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESEND: begin
        if (sts.out_free) begin
          cmd.resend_emit = 1'b1;
          if (sts.resend_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one result is produced per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fill_emit, cmd.resend_emit, cmd.fin_emit}))
    else $error("more than one result in a cycle");

  // A result is loaded only when the result register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill_emit || cmd.resend_emit || cmd.fin_emit) |-> sts.out_free)
    else $error("result loaded over a waiting result");

  // The last resend returns the sequencer to idle
  a_resend_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resend_emit && sts.resend_last) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after last resend");

endmodule
